@@ hdl/assert_macros.svh @@
// Assertion macros used by the filter top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// same-cycle implication
`define CHECK_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("check failed");
// next-cycle implication
`define CHECK_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("check failed");
`endif

@@ hdl/gadf_pkg.sv @@
// Package with widths, constant tables and helper functions of the filter.
`default_nettype none
package gadf_pkg;
   localparam int PIX_BITS   = 10;
   localparam int ROW_BITS   = 5 * PIX_BITS;
   localparam int PIX_MID    = 1 << (PIX_BITS - 1);
   localparam int PIX_MASK   = (1 << PIX_BITS) - 1;
   localparam int FUSE_MAX   = PIX_MID - 1;
   localparam int GRAD_BITS  = PIX_BITS + 1;
   localparam int GABS_BITS  = PIX_BITS + 3;
   localparam int DIV5_BITS  = PIX_BITS;
   localparam int WSIZE_BITS = 6;
   localparam int CFG_BITS   = 32;
   localparam int CSR_IDX_BITS = 2;
   localparam int PX_BITS    = PIX_BITS + 1;
   localparam int WSUM_BITS  = PIX_BITS + 7;
   localparam int AVG_BITS   = PIX_BITS + 1;
   localparam int SUM_BITS   = PIX_BITS + 4;
   localparam int DEN_BITS   = GRAD_BITS + 3;
   localparam int RECIP_BITS = 17;
   localparam int X_BITS     = 14;
   localparam int PROD_BITS  = DEN_BITS + X_BITS;
   localparam int TM_BITS    = 18;
   localparam int MAG_BITS   = GRAD_BITS + SUM_BITS - 1;
   localparam int HOR_BITS   = PIX_BITS + 5;
   localparam int NKER       = 4;
   localparam int NDIR       = 5;
   localparam int DIV5_MUL   = 205;
   localparam int DIV5_SHIFT = 10;
   localparam int QUINT_MUL  = 13108;
   localparam int TWO_Q16    = 2 << 16;
   localparam int GRAD_MAX   = 2 * (((5 * PIX_MASK) * DIV5_MUL) >> DIV5_SHIFT);

   localparam logic [CFG_BITS-1:0] GRAD_CLIP_RST = 32'd656348943;
   localparam logic [CFG_BITS-1:0] WSIZE_THR_RST = 32'd673191952;
   localparam logic [CFG_BITS-1:0] BLEND_RST     = 32'd538976288;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_GRAD_CLIP   = 2'd0,
      CSR_WSIZE_THR   = 2'd1,
      CSR_BLEND_RATIO = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [GRAD_BITS-1:0]  grad;
      logic [WSIZE_BITS-1:0] wsize;
   } meta_type;

   typedef logic [NDIR-1:0][AVG_BITS-1:0] avg_row_type;

   typedef struct packed {
      logic [1:0][MAG_BITS-1:0] mag;
      logic [1:0]               neg;
      logic [1:0][AVG_BITS-1:0] qz;
      logic [1:0][AVG_BITS-1:0] up;
      logic                     gzero;
   } fuse_type;

   localparam logic [WSIZE_BITS-1:0] WSIZE_CLASS [5] = '{6'd16, 6'd23, 6'd31, 6'd39, 6'd40};

   localparam logic [RECIP_BITS-1:0] RECIP_Q16 [65] = '{
      17'd0, 17'd65536, 17'd32768, 17'd21845, 17'd16384, 17'd13107, 17'd10923, 17'd9362,
      17'd8192, 17'd7282, 17'd6554, 17'd5958, 17'd5461, 17'd5041, 17'd4681, 17'd4369,
      17'd4096, 17'd3855, 17'd3641, 17'd3449, 17'd3277, 17'd3120, 17'd2979, 17'd2849,
      17'd2731, 17'd2621, 17'd2521, 17'd2427, 17'd2341, 17'd2259, 17'd2185, 17'd2115,
      17'd2048, 17'd1986, 17'd1928, 17'd1872, 17'd1820, 17'd1771, 17'd1725, 17'd1680,
      17'd1638, 17'd1598, 17'd1560, 17'd1524, 17'd1489, 17'd1456, 17'd1425, 17'd1394,
      17'd1365, 17'd1338, 17'd1311, 17'd1286, 17'd1261, 17'd1238, 17'd1215, 17'd1193,
      17'd1172, 17'd1151, 17'd1132, 17'd1113, 17'd1094, 17'd1076, 17'd1059, 17'd1042,
      17'd1024
   };

   localparam logic [3:0] KERNEL_W [6][5][5] = '{
      '{'{0,0,0,0,0}, '{0,0,0,0,0}, '{0,0,0,0,0}, '{0,0,0,0,0}, '{0,0,0,0,0}},
      '{'{0,0,0,0,0}, '{0,1,2,1,0}, '{0,2,4,2,0}, '{0,1,2,1,0}, '{0,0,0,0,0}},
      '{'{0,0,0,0,0}, '{0,1,1,1,0}, '{0,1,1,1,0}, '{0,1,1,1,0}, '{0,0,0,0,0}},
      '{'{1,1,2,1,1}, '{1,2,4,2,1}, '{2,4,8,4,2}, '{1,2,4,2,1}, '{1,1,2,1,1}},
      '{'{1,1,1,1,1}, '{1,1,1,1,1}, '{1,1,1,1,1}, '{1,1,1,1,1}, '{1,1,1,1,1}},
      '{'{0,0,0,0,0}, '{0,0,0,0,0}, '{0,0,0,0,0}, '{0,0,0,0,0}, '{0,0,0,0,0}}
   };

   function automatic logic [7:0] cfg_byte(input logic [CFG_BITS-1:0] r,
                                           input logic [1:0] k);
      cfg_byte = r[8*k +: 8];
   endfunction

   // direction masks: centre, up, down, left, right
   function automatic logic in_dir(input int d, input int i, input int j);
      in_dir = (d == 0) || (d == 1 && i <= 2) || (d == 2 && i >= 2) ||
               (d == 3 && j <= 2) || (d == 4 && j >= 2);
   endfunction

   function automatic int fsum_of(input int k, input int d);
      int s;
      s = 0;
      for (int i = 0; i < 5; i++)
         for (int j = 0; j < 5; j++)
            if (in_dir(d, i, j))
               s = s + int'(KERNEL_W[k][i][j]);
      fsum_of = (s > 64) ? 64 : s;
   endfunction

   function automatic logic [DIV5_BITS-1:0] div5(input logic [GABS_BITS-1:0] x);
      logic [GABS_BITS+7:0] p;
      p = (GABS_BITS+8)'(x) * (GABS_BITS+8)'(DIV5_MUL);
      div5 = DIV5_BITS'(p >> DIV5_SHIFT);
   endfunction

   function automatic logic [$clog2(DEN_BITS)-1:0] msb_pos(input logic [DEN_BITS-1:0] v);
      logic [$clog2(DEN_BITS)-1:0] m;
      m = '0;
      for (int i = 0; i < DEN_BITS; i++)
         if (v[i])
            m = ($clog2(DEN_BITS))'(i);
      msb_pos = m;
   endfunction

   function automatic logic [AVG_BITS-1:0] scale_avg(input logic signed [WSUM_BITS-1:0] w,
                                                     input logic [RECIP_BITS-1:0] rc);
      logic [WSUM_BITS-1:0] mag;
      logic [WSUM_BITS+RECIP_BITS-1:0] p;
      logic [AVG_BITS-1:0] q;
      mag = w[WSUM_BITS-1] ? WSUM_BITS'(-w) : WSUM_BITS'(w);
      p = (WSUM_BITS+RECIP_BITS)'(mag) * (WSUM_BITS+RECIP_BITS)'(rc);
      q = AVG_BITS'(p >> 16);
      scale_avg = w[WSUM_BITS-1] ? AVG_BITS'(-q) : q;
   endfunction
endpackage
`default_nettype wire

@@ hdl/gradient_adaptive_directional_filter_unit.sv @@
// Top level of the gradient adaptive directional filter pipeline.
// Usage:
//   Input: raise start with a 5x5 window on req_window_row_0..4 (top to
//   bottom, leftmost pixel in the low bits). busy stays low, so a window is
//   taken at every clock edge where start is high.
//   Output: rsp_strobe is high for one cycle with rsp_pixel_out, rsp_gradient
//   and rsp_window_size, once the window has passed the ten register stages.
//   Throughput: one window per clock; the ten register stages each hold
//   one item, and the Newton reciprocal unit is fully pipelined.
//   Configuration: csr_valid with csr_index and csr_wdata writes a register
//   (0 gradient clip levels, 1 window size thresholds, 2 blend ratios);
//   csr_ready is always high. Write only while no window is in flight.
//   Reset: clears the stage valid bits and loads the register defaults;
//   no clearing pass is needed.
//   The receiver cannot stall: each result is shown for one cycle only.
`default_nettype none
`include "assert_macros.svh"
module gradient_adaptive_directional_filter_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [gadf_pkg::ROW_BITS-1:0]   req_window_row_0,
   input  logic [gadf_pkg::ROW_BITS-1:0]   req_window_row_1,
   input  logic [gadf_pkg::ROW_BITS-1:0]   req_window_row_2,
   input  logic [gadf_pkg::ROW_BITS-1:0]   req_window_row_3,
   input  logic [gadf_pkg::ROW_BITS-1:0]   req_window_row_4,
   output logic                            rsp_strobe,
   output logic [gadf_pkg::PIX_BITS-1:0]   rsp_pixel_out,
   output logic [gadf_pkg::GRAD_BITS-1:0]  rsp_gradient,
   output logic [gadf_pkg::WSIZE_BITS-1:0] rsp_window_size,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [gadf_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [gadf_pkg::CFG_BITS-1:0]   csr_wdata
);
   import gadf_pkg::*;

   logic [CFG_BITS-1:0] grad_clip_ff, wsize_thr_ff, blend_ff;
   logic [10:1] v_ff;

   // stage 1
   logic [ROW_BITS-1:0] rows_in [5];
   logic [ROW_BITS-1:0] row_s1_ff [5];
   logic signed [GABS_BITS:0] gh, gv;
   logic [GABS_BITS-1:0] gh_abs_in, gv_abs_in, gh_abs_s1_ff, gv_abs_s1_ff;

   // stage 2
   logic signed [PX_BITS-1:0] px_s1 [5][5];
   logic signed [WSUM_BITS-1:0] wsum_in [NKER][NDIR];
   logic signed [WSUM_BITS-1:0] wsum_s2_ff [NKER][NDIR];
   logic [GRAD_BITS-1:0] grad_in, grad_s2_ff;

   // stage 3
   logic [WSIZE_BITS-1:0] wsize_in;
   logic [2:0] cls_in, cls_s3_ff;
   avg_row_type avg_in [NKER];
   avg_row_type avg_s3_ff [NKER];
   meta_type meta_ff [3:10];

   // stage 4
   avg_row_type pair_lo, pair_hi;
   logic signed [SUM_BITS-1:0] sum_in [2];
   logic signed [SUM_BITS-1:0] sum_s4_ff [2];
   logic [1:0][AVG_BITS-1:0] up_s4_ff;

   // stages 5 to 7
   fuse_type fuse_in;
   fuse_type fuse_ff [5:7];
   logic [SUM_BITS-1:0] sabs [2];
   logic [SUM_BITS+16:0] qzp [2];
   logic [AVG_BITS-1:0] qzm [2];

   // stage 8
   logic [X_BITS-1:0] x_s7;
   logic [MAG_BITS+X_BITS-1:0] qp [2];
   logic [AVG_BITS-1:0] qm [2];
   logic [1:0][AVG_BITS-1:0] fused_in, fused_s8_ff, up_s8_ff;

   // stage 9
   logic [2:0] wdiv;
   logic [1:0] ridx;
   logic signed [8:0] wr, wi;
   logic signed [HOR_BITS+6:0] hacc [2];
   logic signed [HOR_BITS-1:0] hor_s9_ff [2];

   // stage 10
   logic [2:0] r;
   logic signed [HOR_BITS+4:0] mix;
   logic signed [HOR_BITS-1:0] blend;
   logic signed [HOR_BITS:0] outv;
   logic [PIX_BITS-1:0] pixel_in, pixel_ff;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         grad_clip_ff <= GRAD_CLIP_RST;
         wsize_thr_ff <= WSIZE_THR_RST;
         blend_ff     <= BLEND_RST;
         v_ff         <= '0;
      end else begin
         v_ff <= {v_ff[9:1], start};
         if (csr_valid) begin
            unique case (csr_index)
               CSR_GRAD_CLIP:   grad_clip_ff <= csr_wdata;
               CSR_WSIZE_THR:   wsize_thr_ff <= csr_wdata;
               CSR_BLEND_RATIO: blend_ff     <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // stage 1: row and column differences
   always_comb begin
      rows_in[0] = req_window_row_0;
      rows_in[1] = req_window_row_1;
      rows_in[2] = req_window_row_2;
      rows_in[3] = req_window_row_3;
      rows_in[4] = req_window_row_4;
      gh = '0;
      gv = '0;
      for (int c = 0; c < 5; c++) begin
         gh = gh + $signed((GABS_BITS+1)'(rows_in[0][c*PIX_BITS +: PIX_BITS]))
                 - $signed((GABS_BITS+1)'(rows_in[4][c*PIX_BITS +: PIX_BITS]));
         gv = gv + $signed((GABS_BITS+1)'(rows_in[c][0 +: PIX_BITS]))
                 - $signed((GABS_BITS+1)'(rows_in[c][4*PIX_BITS +: PIX_BITS]));
      end
      gh_abs_in = gh[GABS_BITS] ? GABS_BITS'(-gh) : GABS_BITS'(gh);
      gv_abs_in = gv[GABS_BITS] ? GABS_BITS'(-gv) : GABS_BITS'(gv);
   end

   // stage 2: gradient and weighted sums for every kernel and direction
   always_comb begin
      for (int i = 0; i < 5; i++)
         for (int j = 0; j < 5; j++)
            px_s1[i][j] = $signed({1'b0, row_s1_ff[i][j*PIX_BITS +: PIX_BITS]})
                        - $signed(PX_BITS'(PIX_MID));
      for (int k = 0; k < NKER; k++)
         for (int d = 0; d < NDIR; d++) begin
            wsum_in[k][d] = '0;
            for (int i = 0; i < 5; i++)
               for (int j = 0; j < 5; j++)
                  if (in_dir(d, i, j))
                     wsum_in[k][d] = wsum_in[k][d]
                                   + px_s1[i][j] * $signed({1'b0, KERNEL_W[k+1][i][j]});
         end
      grad_in = GRAD_BITS'(div5(gh_abs_s1_ff)) + GRAD_BITS'(div5(gv_abs_s1_ff));
   end

   // stage 3: window size, kernel pair, scaled averages
   always_comb begin
      wsize_in = WSIZE_CLASS[4];
      for (int k = 3; k >= 0; k--)
         if (grad_s2_ff <= GRAD_BITS'(cfg_byte(grad_clip_ff, 2'(k))))
            wsize_in = WSIZE_CLASS[k];
      cls_in = 3'd4;
      for (int k = 3; k >= 0; k--)
         if ({2'b0, wsize_in} < cfg_byte(wsize_thr_ff, 2'(k)))
            cls_in = 3'(k);
      for (int k = 0; k < NKER; k++)
         for (int d = 0; d < NDIR; d++)
            avg_in[k][d] = scale_avg(wsum_s2_ff[k][d], RECIP_Q16[fsum_of(k + 1, d)]);
   end

   // stage 4: pick the kernel pair and sum its averages
   always_comb begin
      unique case (cls_s3_ff)
         3'd0: begin pair_lo = '0;           pair_hi = avg_s3_ff[0]; end
         3'd1: begin pair_lo = avg_s3_ff[0]; pair_hi = avg_s3_ff[1]; end
         3'd2: begin pair_lo = avg_s3_ff[1]; pair_hi = avg_s3_ff[2]; end
         3'd3: begin pair_lo = avg_s3_ff[2]; pair_hi = avg_s3_ff[3]; end
         3'd4: begin pair_lo = avg_s3_ff[3]; pair_hi = '0;           end
         default: begin pair_lo = '0; pair_hi = '0; end
      endcase
      sum_in[0] = '0;
      sum_in[1] = '0;
      for (int d = 0; d < NDIR; d++) begin
         sum_in[0] = sum_in[0] + $signed(pair_lo[d]);
         sum_in[1] = sum_in[1] + $signed(pair_hi[d]);
      end
   end

   // stage 5: fusion numerators and the zero-gradient quotient
   always_comb begin
      for (int s = 0; s < 2; s++) begin
         sabs[s] = sum_s4_ff[s][SUM_BITS-1] ? SUM_BITS'(-sum_s4_ff[s])
                                            : SUM_BITS'(sum_s4_ff[s]);
         qzp[s]  = (SUM_BITS+17)'(sabs[s]) * (SUM_BITS+17)'(QUINT_MUL);
         qzm[s]  = AVG_BITS'(qzp[s] >> 16);
         fuse_in.mag[s] = MAG_BITS'(meta_ff[4].grad) * MAG_BITS'(sabs[s]);
         fuse_in.neg[s] = sum_s4_ff[s][SUM_BITS-1];
         fuse_in.qz[s]  = sum_s4_ff[s][SUM_BITS-1] ? AVG_BITS'(-qzm[s]) : qzm[s];
      end
      fuse_in.up    = up_s4_ff;
      fuse_in.gzero = (meta_ff[4].grad == '0);
   end

   gadf_recip u_recip (
      .clock (clock),
      .grad  (grad_s2_ff),
      .recip (x_s7)
   );

   // stage 8: Newton quotient, saturation
   always_comb begin
      for (int s = 0; s < 2; s++) begin
         qp[s] = (MAG_BITS+X_BITS)'(fuse_ff[7].mag[s]) * (MAG_BITS+X_BITS)'(x_s7);
         if (qp[s][MAG_BITS+X_BITS-1:16] > (MAG_BITS+X_BITS-16)'(FUSE_MAX))
            qm[s] = AVG_BITS'(FUSE_MAX);
         else
            qm[s] = AVG_BITS'(qp[s][MAG_BITS+X_BITS-1:16]);
         if (fuse_ff[7].gzero)
            fused_in[s] = fuse_ff[7].qz[s];
         else
            fused_in[s] = fuse_ff[7].neg[s] ? AVG_BITS'(-qm[s]) : qm[s];
      end
   end

   // stage 9: ratio blend with the up average
   always_comb begin
      wdiv = meta_ff[8].wsize[WSIZE_BITS-1:3];
      if (wdiv < 3'd2)
         ridx = 2'd0;
      else if (wdiv > 3'd5)
         ridx = 2'd3;
      else
         ridx = 2'(wdiv - 3'd2);
      wr = $signed({1'b0, cfg_byte(blend_ff, ridx)});
      wi = 9'sd64 - wr;
      for (int s = 0; s < 2; s++)
         hacc[s] = wr * $signed(fused_s8_ff[s]) + wi * $signed(up_s8_ff[s]);
   end

   // stage 10: interpolation by window size, offset and clamp
   always_comb begin
      r   = meta_ff[9].wsize[2:0];
      mix = hor_s9_ff[0] * $signed({1'b0, r})
          + hor_s9_ff[1] * $signed(5'd8 - {2'b0, r});
      priority if ({2'b0, meta_ff[9].wsize} < cfg_byte(wsize_thr_ff, 2'd0))
         blend = hor_s9_ff[0];
      else if ({2'b0, meta_ff[9].wsize} >= cfg_byte(wsize_thr_ff, 2'd3))
         blend = hor_s9_ff[1];
      else
         blend = HOR_BITS'(mix >>> 3);
      outv = blend + $signed((HOR_BITS+1)'(PIX_MID));
      if (outv < 0)
         pixel_in = '0;
      else if (outv > $signed((HOR_BITS+1)'(PIX_MASK)))
         pixel_in = PIX_BITS'(PIX_MASK);
      else
         pixel_in = PIX_BITS'(outv);
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 5; i++)
         row_s1_ff[i] <= rows_in[i];
      gh_abs_s1_ff <= gh_abs_in;
      gv_abs_s1_ff <= gv_abs_in;
      wsum_s2_ff   <= wsum_in;
      grad_s2_ff   <= grad_in;
      cls_s3_ff    <= cls_in;
      avg_s3_ff    <= avg_in;
      meta_ff[3]   <= '{grad: grad_s2_ff, wsize: wsize_in};
      for (int st = 4; st <= 10; st++)
         meta_ff[st] <= meta_ff[st-1];
      sum_s4_ff    <= sum_in;
      up_s4_ff[0]  <= pair_lo[1];
      up_s4_ff[1]  <= pair_hi[1];
      fuse_ff[5]   <= fuse_in;
      fuse_ff[6]   <= fuse_ff[5];
      fuse_ff[7]   <= fuse_ff[6];
      fused_s8_ff  <= fused_in;
      up_s8_ff     <= fuse_ff[7].up;
      for (int s = 0; s < 2; s++)
         hor_s9_ff[s] <= HOR_BITS'(hacc[s] >>> 6);
      pixel_ff     <= pixel_in;
   end

   assign rsp_strobe      = v_ff[10];
   assign rsp_pixel_out   = pixel_ff;
   assign rsp_gradient    = meta_ff[10].grad;
   assign rsp_window_size = meta_ff[10].wsize;

   `CHECK_IMPL(a_wsize_class, clock, reset, rsp_strobe,
      rsp_window_size == WSIZE_CLASS[0] || rsp_window_size == WSIZE_CLASS[1] ||
      rsp_window_size == WSIZE_CLASS[2] || rsp_window_size == WSIZE_CLASS[3] ||
      rsp_window_size == WSIZE_CLASS[4])
   `CHECK_IMPL(a_grad_range, clock, reset, rsp_strobe, rsp_gradient <= GRAD_BITS'(GRAD_MAX))
   `CHECK_IMPL(a_cls_range, clock, reset, v_ff[3], cls_s3_ff <= 3'd4)
   `CHECK_NEXT(a_fused_bound, clock, reset, v_ff[7],
      $signed(fused_s8_ff[0]) >= -$signed(AVG_BITS'(PIX_MID)) &&
      $signed(fused_s8_ff[1]) >= -$signed(AVG_BITS'(PIX_MID)))
endmodule
`default_nettype wire

@@ hdl/gadf_recip.sv @@
// Pipelined Newton-Raphson reciprocal of five times the gradient, Q16.
`default_nettype none
module gadf_recip (
   input  logic                           clock,
   input  logic [gadf_pkg::GRAD_BITS-1:0] grad,
   output logic [gadf_pkg::X_BITS-1:0]    recip
);
   import gadf_pkg::*;

   logic [DEN_BITS-1:0]  den_in;
   logic [X_BITS-1:0]    x0_in;
   logic [DEN_BITS-1:0]  den_ff [3:5];
   logic [X_BITS-1:0]    x0_ff, x1_ff, x2_ff;
   logic [X_BITS-1:0]    x0_d_ff, x1_d_ff;
   logic [PROD_BITS-1:0] prod0_ff, prod1_ff;
   logic [TM_BITS-1:0]   tm0, tm1;
   logic [X_BITS+TM_BITS-1:0] nx0, nx1;

   always_comb begin
      den_in = (DEN_BITS'(grad) << 2) + DEN_BITS'(grad);
      if (den_in <= DEN_BITS'(64))
         x0_in = X_BITS'(RECIP_Q16[den_in[6:0]]);
      else
         x0_in = X_BITS'(RECIP_BITS'(1) << (5'd16 - 5'(msb_pos(den_in))));
   end

   always_comb begin
      tm0 = (prod0_ff >= PROD_BITS'(TWO_Q16)) ? '0 : TM_BITS'(PROD_BITS'(TWO_Q16) - prod0_ff);
      tm1 = (prod1_ff >= PROD_BITS'(TWO_Q16)) ? '0 : TM_BITS'(PROD_BITS'(TWO_Q16) - prod1_ff);
      nx0 = (X_BITS+TM_BITS)'(x0_d_ff) * (X_BITS+TM_BITS)'(tm0);
      nx1 = (X_BITS+TM_BITS)'(x1_d_ff) * (X_BITS+TM_BITS)'(tm1);
   end

   always_ff @(posedge clock) begin
      den_ff[3] <= den_in;
      x0_ff     <= x0_in;
      den_ff[4] <= den_ff[3];
      prod0_ff  <= PROD_BITS'(den_ff[3]) * PROD_BITS'(x0_ff);
      x0_d_ff   <= x0_ff;
      den_ff[5] <= den_ff[4];
      x1_ff     <= X_BITS'(nx0 >> 16);
      prod1_ff  <= PROD_BITS'(den_ff[5]) * PROD_BITS'(x1_ff);
      x1_d_ff   <= x1_ff;
      x2_ff     <= X_BITS'(nx1 >> 16);
   end

   assign recip = x2_ff;
endmodule
`default_nettype wire
